@@ rtl/core/bsc_pkg.sv @@
`timescale 1ns / 1ps

package bsc_pkg;

  // Run mode, one-hot inside the block
  typedef enum logic [3:0] {
    MODE_STOP  = 4'b0001,
    MODE_UP    = 4'b0010,
    MODE_DOWN  = 4'b0100,
    MODE_PAUSE = 4'b1000
  } mode_e;

  // Mode codes as seen on the mode output
  localparam logic [1:0] MODE_CODE_STOP  = 2'd0;
  localparam logic [1:0] MODE_CODE_UP    = 2'd1;
  localparam logic [1:0] MODE_CODE_DOWN  = 2'd2;
  localparam logic [1:0] MODE_CODE_PAUSE = 2'd3;

  // Item kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEYS = 1'b1;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [2:0] TENS_MAX  = 3'd5;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
    logic [3:0] tenths;
    logic [3:0] hunds;
  } time_t;

  // Bit order matches the key history: bit 0 up ... bit 4 start
  typedef struct packed {
    logic start;
    logic frac;
    logic sec;
    logic down;
    logic up;
  } keys_t;

  typedef struct packed {
    time_t      tm;
    mode_e      mode;
    logic       tick_en;
    logic       buzzer;
    keys_t      prev_keys;
  } state_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] code;
    unique case (m)
      MODE_STOP:  code = MODE_CODE_STOP;
      MODE_UP:    code = MODE_CODE_UP;
      MODE_DOWN:  code = MODE_CODE_DOWN;
      MODE_PAUSE: code = MODE_CODE_PAUSE;
      default:    code = MODE_CODE_STOP;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/bsc_time_step.sv @@
`timescale 1ns / 1ps

// One hundredth up or down with carry/borrow, saturating at 59.99 / 00.00.
module bsc_time_step (
  input  bsc_pkg::time_t tm_i,
  input  logic           up_i,
  output bsc_pkg::time_t tm_o,
  output logic           limit_o
);

  always_comb begin
    tm_o    = tm_i;
    limit_o = 1'b0;
    if (up_i) begin
      priority if (tm_i.hunds < bsc_pkg::DIGIT_MAX) begin
        tm_o.hunds = tm_i.hunds + 4'd1;
      end else if (tm_i.tenths < bsc_pkg::DIGIT_MAX) begin
        tm_o.hunds  = 4'd0;
        tm_o.tenths = tm_i.tenths + 4'd1;
      end else if (tm_i.units < bsc_pkg::DIGIT_MAX) begin
        tm_o.hunds  = 4'd0;
        tm_o.tenths = 4'd0;
        tm_o.units  = tm_i.units + 4'd1;
      end else if (tm_i.tens < bsc_pkg::TENS_MAX) begin
        tm_o.hunds  = 4'd0;
        tm_o.tenths = 4'd0;
        tm_o.units  = 4'd0;
        tm_o.tens   = tm_i.tens + 3'd1;
      end else begin
        tm_o.tens   = bsc_pkg::TENS_MAX;
        tm_o.units  = bsc_pkg::DIGIT_MAX;
        tm_o.tenths = bsc_pkg::DIGIT_MAX;
        tm_o.hunds  = bsc_pkg::DIGIT_MAX;
        limit_o     = 1'b1;
      end
    end else begin
      priority if (tm_i.hunds != 4'd0) begin
        tm_o.hunds = tm_i.hunds - 4'd1;
      end else if (tm_i.tenths != 4'd0) begin
        tm_o.hunds  = bsc_pkg::DIGIT_MAX;
        tm_o.tenths = tm_i.tenths - 4'd1;
      end else if (tm_i.units != 4'd0) begin
        tm_o.hunds  = bsc_pkg::DIGIT_MAX;
        tm_o.tenths = bsc_pkg::DIGIT_MAX;
        tm_o.units  = tm_i.units - 4'd1;
      end else if (tm_i.tens != 3'd0) begin
        tm_o.hunds  = bsc_pkg::DIGIT_MAX;
        tm_o.tenths = bsc_pkg::DIGIT_MAX;
        tm_o.units  = bsc_pkg::DIGIT_MAX;
        tm_o.tens   = tm_i.tens - 3'd1;
      end else begin
        tm_o    = '0;
        limit_o = 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/bsc_update.sv @@
`timescale 1ns / 1ps

// Next-state function for one beat: tick advance or key handling.
module bsc_update (
  input  bsc_pkg::state_t st_i,
  input  logic            op_i,
  input  bsc_pkg::keys_t  keys_i,
  output bsc_pkg::state_t st_o
);

  bsc_pkg::keys_t press;
  bsc_pkg::time_t step_tm;
  bsc_pkg::time_t sec_tm;
  logic           step_up;
  logic           step_limit;
  logic           is_zero;

  assign press   = bsc_pkg::keys_t'(keys_i & ~st_i.prev_keys);
  assign is_zero = (st_i.tm == '0);
  // tick direction follows the mode, key edit direction follows the up press
  assign step_up = (op_i == bsc_pkg::OP_KEYS) ? press.up : (st_i.mode == bsc_pkg::MODE_UP);

  bsc_time_step u_step (
    .tm_i    (st_i.tm),
    .up_i    (step_up),
    .tm_o    (step_tm),
    .limit_o (step_limit)
  );

  // whole seconds step, wraps 59 <-> 00, hundredths untouched
  always_comb begin
    sec_tm = st_i.tm;
    if (press.up) begin
      if (st_i.tm.units < bsc_pkg::DIGIT_MAX) begin
        sec_tm.units = st_i.tm.units + 4'd1;
      end else begin
        sec_tm.units = 4'd0;
        sec_tm.tens  = (st_i.tm.tens < bsc_pkg::TENS_MAX) ? st_i.tm.tens + 3'd1 : 3'd0;
      end
    end else begin
      if (st_i.tm.units != 4'd0) begin
        sec_tm.units = st_i.tm.units - 4'd1;
      end else begin
        sec_tm.units = bsc_pkg::DIGIT_MAX;
        sec_tm.tens  = (st_i.tm.tens != 3'd0) ? st_i.tm.tens - 3'd1 : bsc_pkg::TENS_MAX;
      end
    end
  end

  always_comb begin
    st_o = st_i;
    if (op_i == bsc_pkg::OP_TICK) begin
      if (st_i.tick_en &&
          (st_i.mode == bsc_pkg::MODE_UP || st_i.mode == bsc_pkg::MODE_DOWN)) begin
        st_o.tm = step_tm;
        if (step_limit) begin
          st_o.tick_en = 1'b0;
          st_o.buzzer  = 1'b1;
        end
      end
    end else begin
      st_o.prev_keys = keys_i;
      unique case (st_i.mode)
        bsc_pkg::MODE_STOP: begin
          priority if (press.start) begin
            st_o.mode    = is_zero ? bsc_pkg::MODE_UP : bsc_pkg::MODE_DOWN;
            st_o.tick_en = 1'b1;
          end else if (keys_i.sec) begin
            if (press.up || press.down) begin
              st_o.tm = sec_tm;
            end
          end else if (keys_i.frac) begin
            if (press.up || press.down) begin
              st_o.tm     = step_tm;
              st_o.buzzer = 1'b0;
              if (step_limit) begin
                st_o.tick_en = 1'b0;
              end
            end
          end else begin
            st_o.tm = st_i.tm;
          end
        end
        bsc_pkg::MODE_PAUSE: begin
          if (press.start) begin
            st_o.tm   = '0;
            st_o.mode = bsc_pkg::MODE_STOP;
          end
        end
        bsc_pkg::MODE_UP, bsc_pkg::MODE_DOWN: begin
          if (press.start) begin
            st_o.tick_en = 1'b0;
            st_o.buzzer  = 1'b0;
            st_o.mode    = is_zero ? bsc_pkg::MODE_STOP : bsc_pkg::MODE_PAUSE;
          end
        end
        default: begin
          st_o.mode = st_i.mode;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/bcd_stopwatch_countdown_top.sv @@
// BCD stopwatch / countdown timer, one beat in, one result beat out.
// An accepted beat waits in the input register and moves into the result register
// once the result slot is free or being drained. Throughput: one beat per cycle
// while results are taken; the next-state logic is a single pass of BCD step logic.
// Reset (rst_ni low, asynchronous): time 00.00, stopped, ticks off, buzzer silent,
// all keys released, both pipeline stages empty.
`timescale 1ns / 1ps

module bcd_stopwatch_countdown_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic       key_up_i,
  input  logic       key_down_i,
  input  logic       key_seconds_i,
  input  logic       key_fraction_i,
  input  logic       key_start_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] tens_seconds_o,
  output logic [3:0] unit_seconds_o,
  output logic [3:0] tenths_o,
  output logic [3:0] hundredths_o,
  output logic [1:0] mode_o,
  output logic       buzzer_on_o,
  output logic       ticking_o
);

  // Input register: holds one beat so the source is never stalled by a full result slot
  // for more than the slot itself.
  logic            in_valid_q, in_valid_d;
  logic            op_q;
  bsc_pkg::keys_t  keys_q;

  // Architectural state doubles as the result register: it only changes when the
  // result slot is free or being drained, so it always shows the last result beat.
  bsc_pkg::state_t state_q, state_d;
  logic            out_valid_q, out_valid_d;

  logic            advance;
  logic            in_take;
  bsc_pkg::keys_t  keys_in;

  assign keys_in = '{start: key_start_i, frac: key_fraction_i, sec: key_seconds_i,
                     down: key_down_i, up: key_up_i};

  // result slot can take a new beat when empty or drained this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  bsc_pkg::state_t state_next;

  bsc_update u_update (
    .st_i   (state_q),
    .op_i   (op_q),
    .keys_i (keys_q),
    .st_o   (state_next)
  );

  assign state_d = (in_valid_q && advance) ? state_next : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{tm: '0, mode: bsc_pkg::MODE_STOP, tick_en: 1'b0,
                       buzzer: 1'b0, prev_keys: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= op_i;
      keys_q <= keys_in;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tens_seconds_o = state_q.tm.tens;
  assign unit_seconds_o = state_q.tm.units;
  assign tenths_o       = state_q.tm.tenths;
  assign hundredths_o   = state_q.tm.hunds;
  assign mode_o         = bsc_pkg::mode_code(state_q.mode);
  assign buzzer_on_o    = state_q.buzzer;
  assign ticking_o      = state_q.tick_en;

endmodule

@@ rtl/core/bsc_checker.sv @@
`timescale 1ns / 1ps

module bsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] tens_seconds_o,
  input logic [3:0] unit_seconds_o,
  input logic [3:0] tenths_o,
  input logic [3:0] hundredths_o,
  input logic [1:0] mode_o,
  input logic       buzzer_on_o,
  input logic       ticking_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({tens_seconds_o, unit_seconds_o, tenths_o, hundredths_o,
               mode_o, buzzer_on_o, ticking_o}))
    else $error("result beat changed while stalled");

  // digits stay in BCD range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tens_seconds_o <= 3'd5 && unit_seconds_o <= 4'd9 &&
                    tenths_o <= 4'd9 && hundredths_o <= 4'd9)
    else $error("digit out of range");

  // ticks only run in a counting mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ticking_o |-> mode_o == bsc_pkg::MODE_CODE_UP ||
                                 mode_o == bsc_pkg::MODE_CODE_DOWN)
    else $error("ticking outside a counting mode");

  // the buzzer only sounds once ticks have halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buzzer_on_o |-> !ticking_o)
    else $error("buzzer on while still ticking");

endmodule

bind bcd_stopwatch_countdown_top bsc_checker u_bsc_checker (.*);

@@ tb/bcd_stopwatch_countdown_top_tb.sv @@
`timescale 1ns / 1ps

module bcd_stopwatch_countdown_top_tb;

  typedef bsc_pkg::keys_t keys_t;
  typedef bsc_pkg::time_t time_t;

  localparam logic       OP_TICK         = bsc_pkg::OP_TICK;
  localparam logic       OP_KEYS         = bsc_pkg::OP_KEYS;
  localparam logic [1:0] MODE_CODE_STOP  = bsc_pkg::MODE_CODE_STOP;
  localparam logic [1:0] MODE_CODE_UP    = bsc_pkg::MODE_CODE_UP;
  localparam logic [1:0] MODE_CODE_DOWN  = bsc_pkg::MODE_CODE_DOWN;
  localparam logic [1:0] MODE_CODE_PAUSE = bsc_pkg::MODE_CODE_PAUSE;
  localparam logic [3:0] DIGIT_MAX       = bsc_pkg::DIGIT_MAX;
  localparam logic [2:0] TENS_MAX        = bsc_pkg::TENS_MAX;

  // Run bounds. The slowest correct run, roughly 1k beats with idle gaps and stalls
  // plus one long hold-off, stays well under the limit.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  // Key level bits, same order as keys_t: {start, frac, sec, down, up}
  localparam keys_t K_NONE  = 5'b00000;
  localparam keys_t K_UP    = 5'b00001;
  localparam keys_t K_DOWN  = 5'b00010;
  localparam keys_t K_SEC   = 5'b00100;
  localparam keys_t K_FRAC  = 5'b01000;
  localparam keys_t K_START = 5'b10000;
  localparam keys_t K_ALL   = 5'b11111;

  // Receiver stall styles
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;

  // One result beat as shown on the outputs
  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
    logic [3:0] tenths;
    logic [3:0] hunds;
    logic [1:0] mode;
    logic       buzz;
    logic       tick;
  } readout_t;

  // One directed row; typed = 1 means the readout below is the expected one
  typedef struct packed {
    logic     op;
    keys_t    keys;
    logic     typed;
    readout_t want;
  } stim_row_t;

  localparam readout_t NO_CHECK = '0;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic       op_i           = OP_TICK;
  logic       key_up_i       = 1'b0;
  logic       key_down_i     = 1'b0;
  logic       key_seconds_i  = 1'b0;
  logic       key_fraction_i = 1'b0;
  logic       key_start_i    = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [2:0] tens_seconds_o;
  logic [3:0] unit_seconds_o;
  logic [3:0] tenths_o;
  logic [3:0] hundredths_o;
  logic [1:0] mode_o;
  logic       buzzer_on_o;
  logic       ticking_o;

  bcd_stopwatch_countdown_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .key_up_i       (key_up_i),
    .key_down_i     (key_down_i),
    .key_seconds_i  (key_seconds_i),
    .key_fraction_i (key_fraction_i),
    .key_start_i    (key_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tens_seconds_o (tens_seconds_o),
    .unit_seconds_o (unit_seconds_o),
    .tenths_o       (tenths_o),
    .hundredths_o   (hundredths_o),
    .mode_o         (mode_o),
    .buzzer_on_o    (buzzer_on_o),
    .ticking_o      (ticking_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Stopwatch predictor: own copy of the time, mode and key history.
  // Updated once per accepted input beat.
  // ---------------------------------------------------------------------------
  time_t      w_tm   = '0;
  logic [1:0] w_mode = MODE_CODE_STOP;
  logic       w_tick = 1'b0;
  logic       w_buzz = 1'b0;
  keys_t      w_prev = K_NONE;

  // One hundredth up or down; at 59.99 / 00.00 it sticks, stops ticks and
  // sounds the buzzer.
  function automatic void bump_hundredth(input logic up);
    if (up) begin
      if (w_tm == {TENS_MAX, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX}) begin
        w_tick = 1'b0;
        w_buzz = 1'b1;
      end else if (w_tm.hunds != DIGIT_MAX) begin
        w_tm.hunds = w_tm.hunds + 4'd1;
      end else begin
        w_tm.hunds = '0;
        if (w_tm.tenths != DIGIT_MAX) begin
          w_tm.tenths = w_tm.tenths + 4'd1;
        end else begin
          w_tm.tenths = '0;
          if (w_tm.units != DIGIT_MAX) begin
            w_tm.units = w_tm.units + 4'd1;
          end else begin
            w_tm.units = '0;
            w_tm.tens  = w_tm.tens + 3'd1;
          end
        end
      end
    end else begin
      if (w_tm == '0) begin
        w_tick = 1'b0;
        w_buzz = 1'b1;
      end else if (w_tm.hunds != '0) begin
        w_tm.hunds = w_tm.hunds - 4'd1;
      end else begin
        w_tm.hunds = DIGIT_MAX;
        if (w_tm.tenths != '0) begin
          w_tm.tenths = w_tm.tenths - 4'd1;
        end else begin
          w_tm.tenths = DIGIT_MAX;
          if (w_tm.units != '0) begin
            w_tm.units = w_tm.units - 4'd1;
          end else begin
            w_tm.units = DIGIT_MAX;
            w_tm.tens  = w_tm.tens - 3'd1;
          end
        end
      end
    end
  endfunction

  function automatic readout_t advance_watch(input logic op, input keys_t lvl);
    keys_t press;
    logic  zero;
    if (op == OP_TICK) begin
      // key levels ride along on ticks but are ignored
      if (w_tick && (w_mode == MODE_CODE_UP || w_mode == MODE_CODE_DOWN))
        bump_hundredth(w_mode == MODE_CODE_UP);
    end else begin
      press  = lvl & ~w_prev;
      w_prev = lvl;
      zero   = (w_tm == '0);
      case (w_mode)
        MODE_CODE_STOP: begin
          if (press.start) begin
            w_mode = zero ? MODE_CODE_UP : MODE_CODE_DOWN;
            w_tick = 1'b1;
          end else if (lvl.sec) begin
            // whole seconds wrap 59 <-> 00, hundredths untouched, up wins
            if (press.up) begin
              if (w_tm.units != DIGIT_MAX) begin
                w_tm.units = w_tm.units + 4'd1;
              end else begin
                w_tm.units = '0;
                w_tm.tens  = (w_tm.tens != TENS_MAX) ? w_tm.tens + 3'd1 : 3'd0;
              end
            end else if (press.down) begin
              if (w_tm.units != '0) begin
                w_tm.units = w_tm.units - 4'd1;
              end else begin
                w_tm.units = DIGIT_MAX;
                w_tm.tens  = (w_tm.tens != '0) ? w_tm.tens - 3'd1 : TENS_MAX;
              end
            end
          end else if (lvl.frac && (press.up || press.down)) begin
            // editing saturates but never leaves the buzzer on
            bump_hundredth(press.up);
            w_buzz = 1'b0;
          end
        end
        MODE_CODE_PAUSE: begin
          if (press.start) begin
            w_tm   = '0;
            w_mode = MODE_CODE_STOP;
          end
        end
        default: begin
          if (press.start) begin
            w_tick = 1'b0;
            w_buzz = 1'b0;
            w_mode = zero ? MODE_CODE_STOP : MODE_CODE_PAUSE;
          end
        end
      endcase
    end
    return '{w_tm.tens, w_tm.units, w_tm.tenths, w_tm.hunds, w_mode, w_buzz, w_tick};
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows: extremes, every mode, both saturation points on the
  // floor, a seconds step each way and the key priorities.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [0:24] = '{
    // tick while stopped: nothing moves
    '{OP_TICK, K_NONE, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd0, MODE_CODE_STOP, 1'b0, 1'b0}},
    // fraction step down from 00.00 sticks, buzzer stays silent
    '{OP_KEYS, K_FRAC | K_DOWN, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd0, MODE_CODE_STOP, 1'b0, 1'b0}},
    '{OP_KEYS, K_FRAC | K_UP, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd1, MODE_CODE_STOP, 1'b0, 1'b0}},
    '{OP_KEYS, K_NONE, 1'b0, NO_CHECK},
    // start from a preset counts down
    '{OP_KEYS, K_START, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd1, MODE_CODE_DOWN, 1'b0, 1'b1}},
    '{OP_TICK, K_NONE, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd0, MODE_CODE_DOWN, 1'b0, 1'b1}},
    // underflow: sticks at 00.00, ticks stop, buzzer on
    '{OP_TICK, K_NONE, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd0, MODE_CODE_DOWN, 1'b1, 1'b0}},
    '{OP_TICK, K_ALL, 1'b0, NO_CHECK},
    '{OP_KEYS, K_NONE, 1'b0, NO_CHECK},
    // start while counting at zero goes straight to stopped
    '{OP_KEYS, K_START, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd0, MODE_CODE_STOP, 1'b0, 1'b0}},
    '{OP_KEYS, K_NONE, 1'b0, NO_CHECK},
    // start from 00.00 counts up
    '{OP_KEYS, K_START, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd0, MODE_CODE_UP, 1'b0, 1'b1}},
    '{OP_TICK, K_NONE, 1'b0, NO_CHECK},
    '{OP_TICK, K_NONE, 1'b0, NO_CHECK},
    '{OP_KEYS, K_NONE, 1'b0, NO_CHECK},
    // every key at once while counting: only start matters, pauses
    '{OP_KEYS, K_ALL, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd2, MODE_CODE_PAUSE, 1'b0, 1'b0}},
    '{OP_TICK, K_NONE, 1'b0, NO_CHECK},
    '{OP_KEYS, K_NONE, 1'b0, NO_CHECK},
    // start while paused clears
    '{OP_KEYS, K_START, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd0, MODE_CODE_STOP, 1'b0, 1'b0}},
    '{OP_KEYS, K_SEC | K_UP, 1'b1, '{3'd0, 4'd1, 4'd0, 4'd0, MODE_CODE_STOP, 1'b0, 1'b0}},
    '{OP_KEYS, K_SEC, 1'b0, NO_CHECK},
    '{OP_KEYS, K_SEC | K_DOWN, 1'b1, '{3'd0, 4'd0, 4'd0, 4'd0, MODE_CODE_STOP, 1'b0, 1'b0}},
    '{OP_KEYS, K_FRAC, 1'b0, NO_CHECK},
    // seconds key wins over fraction key
    '{OP_KEYS, K_SEC | K_FRAC | K_UP, 1'b1,
      '{3'd0, 4'd1, 4'd0, 4'd0, MODE_CODE_STOP, 1'b0, 1'b0}},
    '{OP_KEYS, K_NONE, 1'b0, NO_CHECK}
  };

  // ---------------------------------------------------------------------------
  // Expected readouts, oldest first, and mismatch bookkeeping
  // ---------------------------------------------------------------------------
  readout_t readouts_due [$];
  int       mismatches   = 0;
  int       results_seen = 0;
  int       cycle_count  = 0;

  string field_name [7] = '{"tens_seconds", "unit_seconds", "tenths", "hundredths",
                            "mode", "buzzer_on", "ticking"};

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("cycle %0d: mismatch: %s", cycle_count, what);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, readouts_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of beats with random idle gaps. Payload changes at the
  // falling edge; valid stays up across back-to-back beats.
  // ---------------------------------------------------------------------------
  int       burst_left = 0;
  int       beats_sent = 0;
  logic     beat_typed = 1'b0;
  readout_t beat_want  = NO_CHECK;

  task automatic send_beat(input logic op, input keys_t k, input logic typed,
                           input readout_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i       = op;
    {key_start_i, key_fraction_i, key_seconds_i, key_down_i, key_up_i} = k;
    beat_typed = typed;
    beat_want  = want;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    beats_sent++;
  endtask

  // ticks carry junk key levels, which the block has to ignore
  task automatic send_tick();
    send_beat(OP_TICK, keys_t'($urandom_range(0, 31)), 1'b0, NO_CHECK);
  endtask

  task automatic send_keys(input keys_t k);
    send_beat(OP_KEYS, k, 1'b0, NO_CHECK);
  endtask

  task automatic tap_start();
    send_keys(K_START);
    send_keys(K_NONE);
  endtask

  // Input monitor: every accepted beat advances the predictor. Directed rows
  // with a typed readout replace the predicted one.
  always @(posedge clk_i) begin
    readout_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      r = advance_watch(op_i,
                        {key_start_i, key_fraction_i, key_seconds_i, key_down_i, key_up_i});
      if (beat_typed)
        r = beat_want;
      readouts_due.push_back(r);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between stall styles at random; one long hold-off
  // on request so the pipeline backs up into the input.
  // ---------------------------------------------------------------------------
  logic hold_request = 1'b0;
  logic hold_taken   = 1'b0;
  int   hold_left    = 0;
  int   style        = STALL_NONE;
  int   style_left   = 0;
  int   phase        = 0;

  always @(negedge clk_i) begin
    if (hold_request && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      if (style_left == 0) begin
        style      = $urandom_range(STALL_NONE, STALL_PERIODIC);
        style_left = $urandom_range(32, 256);
      end
      style_left--;
      phase++;
      case (style)
        STALL_NONE:   out_ready_i = 1'b1;
        STALL_RANDOM: out_ready_i = ($urandom_range(0, 3) != 0);
        default:      out_ready_i = (phase % 3 == 0);
      endcase
    end
  end

  // Result checker: field by field against the oldest expectation
  always @(posedge clk_i) begin
    readout_t   want;
    logic [3:0] got_f [7];
    logic [3:0] want_f [7];
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (readouts_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want   = readouts_due.pop_front();
        got_f  = '{{1'b0, tens_seconds_o}, unit_seconds_o, tenths_o, hundredths_o,
                   {2'b00, mode_o}, {3'b000, buzzer_on_o}, {3'b000, ticking_o}};
        want_f = '{{1'b0, want.tens}, want.units, want.tenths, want.hunds,
                   {2'b00, want.mode}, {3'b000, want.buzz}, {3'b000, want.tick}};
        for (int f = 0; f < 7; f++) begin
          if (got_f[f] !== want_f[f])
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      results_seen, field_name[f], got_f[f], want_f[f]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int    first;
    int    kind;
    int    n;
    keys_t held;
    keys_t dir;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].keys, directed_rows[i].typed,
                directed_rows[i].want);

    // Top of the range by editing: 01.00 -> 00.99 by one fraction step, the
    // seconds wrap 00 -> 59 gives 59.99, and a fraction press against 59.99
    // must stay there and stay silent.
    send_keys(K_FRAC | K_DOWN);
    send_keys(K_NONE);
    send_keys(K_SEC | K_DOWN);
    send_keys(K_SEC);
    send_keys(K_FRAC | K_UP);
    send_keys(K_NONE);
    tap_start();              // count down from 59.99

    // The long receiver hold-off lands here, while ticks keep coming.
    hold_request = 1'b1;
    repeat (40) send_tick();
    tap_start();              // pause
    tap_start();              // clear

    // Short count up from 00.00.
    tap_start();
    repeat (20) send_tick();
    tap_start();              // pause
    tap_start();              // clear

    // Random part: mostly well-formed edit and run sequences, some noise.
    first = beats_sent;
    while (beats_sent - first < RANDOM_BEATS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        // edit session: hold a modifier, tap up/down a few times
        held = $urandom_range(0, 1) ? K_SEC : K_FRAC;
        if ($urandom_range(0, 7) == 0)
          held = K_SEC | K_FRAC;
        n = $urandom_range(1, 8);
        send_keys(held);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0, 1:    dir = K_UP;
            2, 3:    dir = K_DOWN;
            default: dir = K_UP | K_DOWN;
          endcase
          send_keys(held | dir);
          send_keys(held);
        end
        send_keys(K_NONE);
      end else if (kind <= 5) begin
        // run: start, ticks with stray key samples, then pause or stop
        tap_start();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 40);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0)
            send_keys(keys_t'($urandom_range(0, 31)) & ~K_START);
          else
            send_tick();
        end
        tap_start();
        if ($urandom_range(0, 1))
          tap_start();
      end else if (kind == 6) begin
        send_keys(K_NONE);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1))
            send_tick();
          else
            send_keys(keys_t'($urandom_range(0, 31)));
        end
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;

    // wait for the last results, then wait out the drain period for anything extra
    while (readouts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && readouts_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
